@@ hdl/kaut_pkg.sv @@
// shared types and constants of the knob angle unwrap tracker
package kaut_pkg;

  localparam int ANGLE_FRAC_BITS = 4;
  localparam int SPEED_FRAC_BITS = 16;

  localparam int ANGLE_W = 13;
  localparam int STAMP_W = 32;
  localparam int SPEED_W = 32;
  localparam int POS_W   = 32;
  localparam int POS_OUT_W = 28;
  localparam int DZ_W    = 12;
  localparam int LIMIT_W = 31;

  // |unwrapped change| never exceeds the largest 13-bit angle
  localparam int MAG_W   = ANGLE_W;
  localparam int DELTA_W = 20;
  localparam int QUO_W   = MAG_W + SPEED_FRAC_BITS;
  localparam int CNT_W   = $clog2(QUO_W + 1);

  localparam logic signed [DELTA_W-1:0] HALF_TURN = DELTA_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [DELTA_W-1:0] FULL_TURN = DELTA_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [DELTA_W-1:0] NEG_HALF_TURN = -HALF_TURN;

  localparam logic signed [39:0] W_OLD = 40'sd179;
  localparam logic signed [39:0] W_NEW = 40'sd77;
  localparam logic signed [40:0] BLEND_ROUND = 41'sd128;

  // configuration register indexes
  localparam logic [7:0] REG_DEAD_ZONE   = 8'd0;
  localparam logic [7:0] REG_SPEED_LIMIT = 8'd1;

  localparam logic [1:0] DIR_STILL = 2'b00;
  localparam logic [1:0] DIR_FWD   = 2'b01;
  localparam logic [1:0] DIR_BACK  = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_SIGN,
    ST_BLEND,
    ST_EMIT
  } state_e;

endpackage

@@ hdl/kaut_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module kaut_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [kaut_pkg::QUO_W-1:0]  dividend_i,
  input  logic [kaut_pkg::STAMP_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [kaut_pkg::QUO_W-1:0]  quotient_o
);

  logic [kaut_pkg::STAMP_W-1:0] rem_q, rem_d;
  logic [kaut_pkg::STAMP_W-1:0] dvs_q;
  logic [kaut_pkg::QUO_W-1:0]   quo_q, quo_d;
  logic [kaut_pkg::CNT_W-1:0]   cnt_q;
  logic                         busy_q;
  logic                         done_q;
  logic [kaut_pkg::STAMP_W:0]   shifted;
  logic [kaut_pkg::STAMP_W:0]   diff;
  logic                         fits;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    shifted = {rem_q, quo_q[kaut_pkg::QUO_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = ~diff[kaut_pkg::STAMP_W];
    rem_d   = fits ? diff[kaut_pkg::STAMP_W-1:0] : shifted[kaut_pkg::STAMP_W-1:0];
    quo_d   = {quo_q[kaut_pkg::QUO_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= kaut_pkg::CNT_W'(kaut_pkg::QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == kaut_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hdl/knob_angle_unwrap_tracker.sv @@
// top level of the knob angle unwrap tracker
//
// s_axis carries one sample per transfer: a knob angle in sixteenths of a
// degree and a free-running cycle stamp. m_axis returns exactly one result
// per sample: position in whole degrees, tracked speed, direction and the
// moved / zero-elapsed-time flags. cfg_* writes the dead zone (index 0) and
// the speed limit (index 1); unknown indexes are dropped. cfg_ready_o is
// always high; write only while no sample is in flight.
//
// one sample is worked on at a time. a still sample or one with zero elapsed
// time goes from the calc step straight to the emit step; a moving sample
// first passes the bit-serial divider, which yields 13 + SPEED_FRAC_BITS
// quotient bits, one per cycle, then the sign step and, when smoothed, the
// blend step. the next sample is taken in the idle step that follows the
// load of the output register; a stalled receiver holds the finished result
// there, the current sample then waits in the emit step and no new sample is
// taken.
//
// reset clears all tracking state to zero, loads the register defaults
// (dead zone 16, speed limit 65536) and empties the output register.
module knob_angle_unwrap_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // angle_in [12:0], stamp [44:13], zero fill [47:45]
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // position_deg [27:0], speed_out [59:28], turn_dir [61:60],
  // moved [62], time_fault [63]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  kaut_pkg::state_e state_q, state_d;

  // configuration
  logic [kaut_pkg::DZ_W-1:0]    dead_zone_q;
  logic [kaut_pkg::LIMIT_W-1:0] speed_limit_q;

  // latched sample
  logic [kaut_pkg::ANGLE_W-1:0] angle_q;
  logic [kaut_pkg::STAMP_W-1:0] stamp_q;

  // tracking state
  logic [kaut_pkg::ANGLE_W-1:0]        prev_angle_q;
  logic [kaut_pkg::STAMP_W-1:0]        prev_stamp_q;
  logic signed [kaut_pkg::SPEED_W-1:0] smooth_q;
  logic signed [kaut_pkg::POS_W-1:0]   pos_acc_q;
  logic [1:0]                          dir_q;

  // per-sample working registers
  logic              neg_q;
  logic [1:0]        new_dir_q;
  logic              moved_q;
  logic              fault_q;
  logic signed [39:0] p_old_q;
  logic signed [39:0] p_new_q;

  // output register
  logic        m_valid_q;
  logic [63:0] m_data_q;

  // fsm strobes
  logic accept;
  logic calc_still;
  logic calc_fault;
  logic sign_bypass;
  logic out_load;

  logic                        div_start;
  logic                        div_done;
  logic [kaut_pkg::QUO_W-1:0]  quotient;
  logic [kaut_pkg::QUO_W-1:0]  dividend;
  logic [kaut_pkg::STAMP_W-1:0] elapsed;

  // unwrap datapath
  logic signed [kaut_pkg::DELTA_W-1:0] d_raw;
  logic signed [kaut_pkg::DELTA_W-1:0] d_wr;
  logic signed [kaut_pkg::DELTA_W-1:0] d_mag;
  logic [1:0]                          dir_calc;
  logic signed [kaut_pkg::POS_W:0]     pos_sum;
  logic signed [kaut_pkg::POS_W-1:0]   pos_sat;

  // speed datapath
  logic [63:0]                         quo_x;
  logic signed [kaut_pkg::SPEED_W-1:0] raw_speed;
  logic [kaut_pkg::SPEED_W-1:0]        raw_mag;
  logic signed [40:0]                  blend_sum;

  // position readout, truncated toward zero
  logic signed [kaut_pkg::POS_W-1:0] pos_adj;
  logic signed [kaut_pkg::POS_W-1:0] pos_div;

  assign accept      = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // unwrap and dead zone
  // ---------------------------------------------------------------------
  always_comb begin
    d_raw = signed'(kaut_pkg::DELTA_W'(angle_q)) - signed'(kaut_pkg::DELTA_W'(prev_angle_q));
    if (d_raw > kaut_pkg::HALF_TURN) begin
      d_wr = d_raw - kaut_pkg::FULL_TURN;
    end else if (d_raw < kaut_pkg::NEG_HALF_TURN) begin
      d_wr = d_raw + kaut_pkg::FULL_TURN;
    end else begin
      d_wr = d_raw;
    end
    d_mag = d_wr[kaut_pkg::DELTA_W-1] ? -d_wr : d_wr;
    if (d_wr[kaut_pkg::DELTA_W-1]) begin
      dir_calc = kaut_pkg::DIR_BACK;
    end else if (d_wr != '0) begin
      dir_calc = kaut_pkg::DIR_FWD;
    end else begin
      dir_calc = kaut_pkg::DIR_STILL;
    end
    calc_still = unsigned'(d_mag) < kaut_pkg::DELTA_W'(dead_zone_q);
    elapsed    = stamp_q - prev_stamp_q;
    calc_fault = (elapsed == '0);
    dividend   = {d_mag[kaut_pkg::MAG_W-1:0], {kaut_pkg::SPEED_FRAC_BITS{1'b0}}};
    // saturating position update
    pos_sum = (kaut_pkg::POS_W+1)'(pos_acc_q) + (kaut_pkg::POS_W+1)'(d_wr);
    if (pos_sum[kaut_pkg::POS_W] != pos_sum[kaut_pkg::POS_W-1]) begin
      pos_sat = pos_sum[kaut_pkg::POS_W] ? {1'b1, {(kaut_pkg::POS_W-1){1'b0}}}
                                         : {1'b0, {(kaut_pkg::POS_W-1){1'b1}}};
    end else begin
      pos_sat = pos_sum[kaut_pkg::POS_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // signed, saturated raw speed and bypass decision
  // ---------------------------------------------------------------------
  always_comb begin
    quo_x = 64'(quotient);
    if (neg_q) begin
      raw_speed = (quo_x > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : -quo_x[31:0];
    end else begin
      raw_speed = (quo_x > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo_x[31:0];
    end
    raw_mag     = raw_speed[kaut_pkg::SPEED_W-1] ? -raw_speed : raw_speed;
    sign_bypass = (new_dir_q != dir_q) || (raw_mag > {1'b0, speed_limit_q});
    // 179/256 old plus 77/256 new, floor after the half-step bias
    blend_sum   = 41'(p_old_q) + 41'(p_new_q) + kaut_pkg::BLEND_ROUND;
  end

  always_comb begin
    pos_adj = pos_acc_q + (pos_acc_q[kaut_pkg::POS_W-1]
              ? kaut_pkg::POS_W'((1 << kaut_pkg::ANGLE_FRAC_BITS) - 1) : '0);
    pos_div = pos_adj >>> kaut_pkg::ANGLE_FRAC_BITS;
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kaut_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      kaut_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = kaut_pkg::ST_CALC;
        end
      end
      kaut_pkg::ST_CALC: begin
        if (calc_still || calc_fault) begin
          state_d = kaut_pkg::ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = kaut_pkg::ST_DIV;
        end
      end
      kaut_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = kaut_pkg::ST_SIGN;
        end
      end
      kaut_pkg::ST_SIGN: begin
        state_d = sign_bypass ? kaut_pkg::ST_EMIT : kaut_pkg::ST_BLEND;
      end
      kaut_pkg::ST_BLEND: begin
        state_d = kaut_pkg::ST_EMIT;
      end
      kaut_pkg::ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = kaut_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kaut_pkg::ST_IDLE;
      end
    endcase
  end

  kaut_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (elapsed),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // ---------------------------------------------------------------------
  // configuration and tracking state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q   <= kaut_pkg::DZ_W'(16);
      speed_limit_q <= kaut_pkg::LIMIT_W'(65536);
      prev_angle_q  <= '0;
      prev_stamp_q  <= '0;
      smooth_q      <= '0;
      pos_acc_q     <= '0;
      dir_q         <= kaut_pkg::DIR_STILL;
      m_valid_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == kaut_pkg::REG_DEAD_ZONE) begin
          dead_zone_q <= cfg_data_i[kaut_pkg::DZ_W-1:0];
        end else if (cfg_index_i == kaut_pkg::REG_SPEED_LIMIT) begin
          speed_limit_q <= cfg_data_i[kaut_pkg::LIMIT_W-1:0];
        end
      end
      if (state_q == kaut_pkg::ST_CALC) begin
        if (calc_still) begin
          dir_q <= kaut_pkg::DIR_STILL;
        end else begin
          // drift below the dead zone keeps building against this angle
          prev_angle_q <= angle_q;
          prev_stamp_q <= stamp_q;
          pos_acc_q    <= pos_sat;
        end
      end
      if (state_q == kaut_pkg::ST_SIGN && sign_bypass) begin
        smooth_q <= raw_speed;
        dir_q    <= new_dir_q;
      end
      if (state_q == kaut_pkg::ST_BLEND) begin
        smooth_q <= blend_sum[39:8];
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      angle_q <= s_axis_tdata[12:0];
      stamp_q <= s_axis_tdata[44:13];
    end
    if (state_q == kaut_pkg::ST_CALC) begin
      neg_q     <= d_wr[kaut_pkg::DELTA_W-1];
      new_dir_q <= dir_calc;
      moved_q   <= ~calc_still;
      fault_q   <= ~calc_still & calc_fault;
    end
    if (state_q == kaut_pkg::ST_SIGN) begin
      p_old_q <= 40'(smooth_q) * kaut_pkg::W_OLD;
      p_new_q <= 40'(raw_speed) * kaut_pkg::W_NEW;
    end
    if (out_load) begin
      m_data_q <= {fault_q, moved_q, dir_q, smooth_q,
                   pos_div[kaut_pkg::POS_OUT_W-1:0]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == kaut_pkg::ST_CALC)
    else $error("accepted sample did not enter the calc step");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == kaut_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

  a_fault_needs_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[63] && !m_axis_tdata[62]))
    else $error("time fault flagged on a still sample");

  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[61:60] != 2'b10)
    else $error("direction field holds an unused code");

endmodule
